[rtl/core/mrcc_pkg.sv]
package mrcc_pkg;

    localparam int ADDR_BITS = 32;
    localparam int QDEPTH    = 2;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_INVAL  = 2'd1,
        ST_NOMAP  = 2'd2,
        ST_BADVEC = 2'd3
    } status_t;

    localparam logic [2:0] OP_ADVISE     = 3'd0;
    localparam logic [2:0] OP_QUERY      = 3'd1;
    localparam logic [2:0] OP_LOCK       = 3'd2;
    localparam logic [2:0] OP_LOCK_ALL   = 3'd3;
    localparam logic [2:0] OP_UNLOCK_ALL = 3'd4;

    localparam logic [1:0] REG_PAGE_SHIFT   = 2'd0;
    localparam logic [1:0] REG_PAGE_KNOWN   = 2'd1;
    localparam logic [1:0] REG_REGION_COUNT = 2'd2;

    // Highest advice code (will-need / dont-need family) and the lock-all flags.
    localparam logic [7:0] ADVICE_MAX      = 8'd4;
    localparam logic [7:0] LOCK_FLAGS_MASK = 8'h03;

    typedef struct packed {
        logic [4:0] page_shift;
        logic       page_known;
        logic [4:0] region_count;
    } cfg_t;

    // One queued request: a table load or a classified validation request.
    typedef struct packed {
        logic                 is_load;
        logic [3:0]           slot;
        logic [ADDR_BITS-1:0] word_a;   // region start, or request address
        logic [ADDR_BITS-1:0] word_b;   // region end, or request length
        logic [2:0]           perms;
        status_t              status;   // final status when no scan is needed
        logic                 scan;
        logic [ADDR_BITS:0]   pages;    // page count reported on success
    } qent_t;

endpackage

[rtl/core/mrcc_front.sv]
module mrcc_front
    import mrcc_pkg::*;
(
    input  cfg_t        cfg,
    input  logic        kind,
    input  logic [3:0]  slot,
    input  logic [31:0] region_start,
    input  logic [31:0] region_end,
    input  logic [2:0]  region_perms,
    input  logic [2:0]  op,
    input  logic [31:0] address,
    input  logic [31:0] length,
    input  logic [7:0]  advice_or_flags,
    input  logic [31:0] vec_address,
    output qent_t       ent
);

    logic [31:0] pmask;
    logic        mis;
    logic [32:0] range_sum;
    logic        wrap;
    logic [33:0] round_sum;
    logic [33:0] np_wide;
    logic [32:0] np;
    logic [33:0] vec_sum;
    logic        badvec;

    assign pmask     = (32'h1 << cfg.page_shift) - 32'h1;
    assign mis       = |(address & pmask);
    assign range_sum = {1'b0, address} + {1'b0, length};
    assign wrap      = range_sum[32];
    assign round_sum = {2'b00, length} + {2'b00, pmask};
    assign np_wide   = round_sum >> cfg.page_shift;
    assign np        = np_wide[32:0];
    assign vec_sum   = {2'b00, vec_address} + {1'b0, np};
    assign badvec    = (vec_address == 32'h0) || (vec_sum[33:32] != 2'b00);

    always_comb
    begin
        ent         = '0;
        ent.is_load = !kind;
        ent.slot    = slot;
        ent.perms   = region_perms;
        ent.word_a  = kind ? address : region_start;
        ent.word_b  = kind ? length : region_end;
        ent.status  = ST_OK;
        unique case (op)
            OP_ADVISE:
            begin
                if (!cfg.page_known || mis || length == 32'h0 || advice_or_flags > ADVICE_MAX)
                    ent.status = ST_INVAL;
                else if (wrap)
                    ent.status = ST_NOMAP;
                else
                    ent.scan = 1'b1;
            end
            OP_QUERY:
            begin
                if (!cfg.page_known || mis)
                    ent.status = ST_INVAL;
                else if (wrap)
                    ent.status = ST_NOMAP;
                else if (badvec)
                    ent.status = ST_BADVEC;
                else
                begin
                    ent.scan  = 1'b1;
                    ent.pages = np;
                end
            end
            OP_LOCK:
            begin
                if (wrap || !cfg.page_known || mis)
                    ent.status = ST_INVAL;
                else
                    ent.scan = 1'b1;
            end
            OP_LOCK_ALL:
            begin
                if ((advice_or_flags & ~LOCK_FLAGS_MASK) != 8'h00)
                    ent.status = ST_INVAL;
            end
            OP_UNLOCK_ALL:
                ent.status = ST_OK;
            default:
                ent.status = ST_INVAL;
        endcase
        if (!kind)
            ent.scan = 1'b0;
    end

endmodule

[rtl/core/mrcc_queue.sv]
module mrcc_queue
    import mrcc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  qent_t push_ent,
    input  logic  pop,
    output qent_t head,
    output logic  empty,
    output logic  full
);

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW = $clog2(QDEPTH + 1);

    qent_t          slots_reg [QDEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CW'(QDEPTH));
    assign head  = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_ent;
    end

endmodule

[rtl/core/mrcc_back.sv]
module mrcc_back
    import mrcc_pkg::*;
#(
    parameter int MAX_REGIONS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  qent_t        head,
    input  logic         q_empty,
    output logic         pop,
    input  logic [4:0]   region_count,
    output logic         out_valid,
    input  logic         out_stall,
    output logic [1:0]   status,
    output logic [32:0]  page_count
);

    localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int NW = $clog2(MAX_REGIONS + 1);
    localparam int KW = (NW > 5) ? NW : 5;

    typedef enum logic [2:0] {
        B_IDLE  = 3'b001,
        B_READ  = 3'b010,
        B_CHECK = 3'b100
    } bstate_t;

    logic [ADDR_BITS-1:0] start_mem [MAX_REGIONS];
    logic [ADDR_BITS-1:0] end_mem   [MAX_REGIONS];
    logic [2:0]           perms_mem [MAX_REGIONS];
    logic [MAX_REGIONS-1:0] valid_reg;

    logic [ADDR_BITS-1:0] rd_start_reg, rd_end_reg;
    logic [2:0]           rd_perms_reg;
    logic                 rd_valid_reg;

    bstate_t              state_reg, state_next;
    logic [IW-1:0]        idx_reg, idx_next;
    logic [NW-1:0]        pass_reg, pass_next;
    logic [ADDR_BITS-1:0] a_reg, a_next;
    logic [ADDR_BITS-1:0] rem_reg, rem_next;
    logic [32:0]          pages_reg, pages_next;
    logic                 out_valid_reg, out_valid_next;
    status_t              status_reg, status_next;
    logic [32:0]          page_count_reg, page_count_next;

    logic                 we;
    logic [IW-1:0]        wr_idx;
    logic                 slot_ok;
    logic [KW-1:0]        rc_ext;
    logic [NW-1:0]        n_used;
    logic                 last;
    logic                 out_free;
    logic [ADDR_BITS-1:0] e_start, e_end, span;
    logic [2:0]           e_perms;
    logic                 match;

    assign slot_ok = (KW'(head.slot) < KW'(MAX_REGIONS));
    assign wr_idx  = IW'(head.slot);
    assign rc_ext  = KW'(region_count);
    assign n_used  = (rc_ext > KW'(MAX_REGIONS)) ? NW'(MAX_REGIONS) : NW'(rc_ext);
    assign last    = (NW'(idx_reg) + 1'b1) == n_used;
    assign out_free = !out_valid_reg || !out_stall;

    // Entries never loaded read as the all-zero reset entry.
    assign e_start = rd_valid_reg ? rd_start_reg : '0;
    assign e_end   = rd_valid_reg ? rd_end_reg : '0;
    assign e_perms = rd_valid_reg ? rd_perms_reg : '0;
    assign match   = (e_start <= a_reg) && (e_end > a_reg);
    assign span    = e_end - a_reg;

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        pass_next       = pass_reg;
        a_next          = a_reg;
        rem_next        = rem_reg;
        pages_next      = pages_reg;
        out_valid_next  = out_valid_reg && out_stall;
        status_next     = status_reg;
        page_count_next = page_count_reg;
        pop             = 1'b0;
        we              = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    if (head.is_load)
                    begin
                        we  = slot_ok;
                        pop = 1'b1;
                    end
                    else if (!head.scan || n_used == '0)
                    begin
                        if (out_free)
                        begin
                            pop             = 1'b1;
                            out_valid_next  = 1'b1;
                            status_next     = head.scan ? ST_NOMAP : head.status;
                            page_count_next = '0;
                        end
                    end
                    else
                    begin
                        pop        = 1'b1;
                        a_next     = head.word_a;
                        rem_next   = head.word_b;
                        pages_next = head.pages;
                        idx_next   = '0;
                        pass_next  = '0;
                        state_next = B_READ;
                    end
                end
            end
            B_READ:
                state_next = B_CHECK;
            B_CHECK:
            begin
                priority if (match && e_perms != 3'b000 && span < rem_reg
                             && pass_reg != NW'(MAX_REGIONS))
                begin
                    a_next     = e_end;
                    rem_next   = rem_reg - span;
                    idx_next   = '0;
                    pass_next  = pass_reg + 1'b1;
                    state_next = B_READ;
                end
                else if (!match && !last)
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = B_READ;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (match && e_perms != 3'b000 && span >= rem_reg)
                    begin
                        status_next     = ST_OK;
                        page_count_next = pages_reg;
                    end
                    else
                    begin
                        status_next     = ST_NOMAP;
                        page_count_next = '0;
                    end
                    state_next = B_IDLE;
                end
            end
            default:
                state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (we)
                valid_reg[wr_idx] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        pass_reg       <= pass_next;
        a_reg          <= a_next;
        rem_reg        <= rem_next;
        pages_reg      <= pages_next;
        status_reg     <= status_next;
        page_count_reg <= page_count_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            start_mem[wr_idx] <= head.word_a;
            end_mem[wr_idx]   <= head.word_b;
            perms_mem[wr_idx] <= head.perms;
        end
        rd_start_reg <= start_mem[idx_reg];
        rd_end_reg   <= end_mem[idx_reg];
        rd_perms_reg <= perms_mem[idx_reg];
        rd_valid_reg <= valid_reg[idx_reg];
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign page_count = page_count_reg;

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> state_reg == B_IDLE)
        else $error("queue popped while a scan was running");

    a_fail_no_pages: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg != ST_OK |-> page_count_reg == '0)
        else $error("failed request reports pages");

    a_read_then_check: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_READ |=> state_reg == B_CHECK)
        else $error("table read not followed by a check");

endmodule

[rtl/core/memory_range_coverage_checker_core.sv]
// Memory range coverage checker.
// The input channel (in_valid / in_stall) carries two kinds of request: a
// table load (kind 0) that writes one region entry, and a validation request
// (kind 1) that answers with one result on the output channel (out_valid /
// out_stall) holding a status code and, for a residency query, a page count.
// Requests are classified on entry and placed in a two-entry queue; in_stall
// is high only while that queue is full. The back end drains the queue in
// order, so loads and checks always see the table in request order.
// A load is popped by the back end and written into its table entry. A
// request decided by its argument checks is queued and, at the head of the
// queue, moves into the output register once that register is free. A
// request that needs the coverage scan examines table entries in turn, each
// with a registered table read and a compare, restarting from entry zero
// each time the chain moves past a region. Reset clears the table to
// all-zero entries, sets page_shift to 12, page_size_known to 1 and
// region_count to 0. A stalled result holds in the output register; the
// back end then waits, and the queue keeps accepting until it fills. The
// user must see that configuration is written over the APB port only while idle.
module memory_range_coverage_checker_core
    import mrcc_pkg::*;
#(
    parameter int MAX_REGIONS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [3:0]  slot,
    input  logic [31:0] region_start,
    input  logic [31:0] region_end,
    input  logic [2:0]  region_perms,
    input  logic [2:0]  op,
    input  logic [31:0] address,
    input  logic [31:0] length,
    input  logic [7:0]  advice_or_flags,
    input  logic [31:0] vec_address,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [32:0] page_count
);

    cfg_t  cfg_reg;
    qent_t front_ent;
    qent_t q_head;
    logic  q_empty;
    logic  q_full;
    logic  q_pop;
    logic  cfg_write;

    // The port never inserts wait states.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.page_shift   <= 5'd12;
            cfg_reg.page_known   <= 1'b1;
            cfg_reg.region_count <= 5'd0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_PAGE_SHIFT:   cfg_reg.page_shift   <= pwdata[4:0];
                REG_PAGE_KNOWN:   cfg_reg.page_known   <= pwdata[0];
                REG_REGION_COUNT: cfg_reg.region_count <= pwdata[4:0];
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_PAGE_SHIFT:   prdata = {27'h0, cfg_reg.page_shift};
            REG_PAGE_KNOWN:   prdata = {31'h0, cfg_reg.page_known};
            REG_REGION_COUNT: prdata = {27'h0, cfg_reg.region_count};
            default:          prdata = 32'h0;
        endcase
    end

    assign in_stall = q_full;

    mrcc_front u_front (
        .cfg             (cfg_reg),
        .kind            (kind),
        .slot            (slot),
        .region_start    (region_start),
        .region_end      (region_end),
        .region_perms    (region_perms),
        .op              (op),
        .address         (address),
        .length          (length),
        .advice_or_flags (advice_or_flags),
        .vec_address     (vec_address),
        .ent             (front_ent)
    );

    mrcc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (in_valid && !q_full),
        .push_ent (front_ent),
        .pop      (q_pop),
        .head     (q_head),
        .empty    (q_empty),
        .full     (q_full)
    );

    mrcc_back #(
        .MAX_REGIONS (MAX_REGIONS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (q_head),
        .q_empty      (q_empty),
        .pop          (q_pop),
        .region_count (cfg_reg.region_count),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .page_count   (page_count)
    );

endmodule
